[rtl/cftr_pkg.sv]
// Shared types and constants of the finger table router.
`default_nettype none

package cftr_pkg;

  localparam int ID_W   = 16;
  localparam int FIDX_W = 4;

  typedef enum logic [2:0] {
    OP_LOOKUP   = 3'd0,
    OP_NEXT_TGT = 3'd1,
    OP_WR_FING  = 3'd2,
    OP_NOTIFY   = 3'd3,
    OP_STABIL   = 3'd4,
    OP_SET_SUCC = 3'd5,
    OP_RESTART  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OWNS    = 2'd0,
    ST_FORWARD = 2'd1,
    ST_TARGET  = 2'd2,
    ST_UPDATED = 2'd3
  } status_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } cftr_cmd_t;

endpackage

`default_nettype wire

[rtl/cftr_dp.sv]
// Datapath of the finger table router: routing state, range compares and result register.
`default_nettype none

module cftr_dp import cftr_pkg::*; #(
  parameter int ID_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cftr_cmd_t         cmd,
  input  wire logic              cfg_wr_en,
  input  wire logic [ID_W-1:0]   cfg_wr_data,
  input  wire logic [2:0]        in_op,
  input  wire logic [ID_W-1:0]   in_key,
  input  wire logic [ID_W-1:0]   in_node,
  input  wire logic [FIDX_W-1:0] in_fidx,
  output logic [1:0]             out_status,
  output logic [ID_W-1:0]        out_node,
  output logic [FIDX_W-1:0]      out_fidx,
  output logic [ID_W-1:0]        out_succ,
  output logic [ID_W-1:0]        out_pred
);

  localparam int AW = (ID_BITS > ID_W) ? ID_BITS : ID_W;
  localparam int CW = AW + 2;
  localparam int PW = $clog2(ID_BITS + 1);

  typedef logic signed [CW-1:0] cval_t;

  localparam cval_t MAX_ID = cval_t'(CW'(1) << ID_BITS);
  localparam logic [AW-1:0] ID_MASK = AW'((65'(1) << ID_BITS) - 65'(1));

  function automatic logic in_range(cval_t x, cval_t b, cval_t e);
    logic r;
    if (b < e) begin
      r = (b <= x) && (x <= e);
    end else if (b > e) begin
      r = ((b <= x) && (x <= MAX_ID)) || ((x >= 0) && (x <= e));
    end else begin
      r = (x == b);
    end
    return r;
  endfunction

  logic [ID_W-1:0] own_id;
  logic [ID_W-1:0] fingers [ID_BITS];
  logic [ID_W-1:0] succ;
  logic [ID_W-1:0] pred;
  logic [PW-1:0]   ptr;

  logic [2:0]         cap_op;
  logic [ID_W-1:0]    cap_node;
  logic [FIDX_W-1:0]  cap_fidx;
  logic [ID_BITS-1:0] cap_hit;
  logic               cap_owns;
  logic               cap_succ_own;
  logic               cap_notify_ok;
  logic               cap_stab_ok;

  cval_t              own_c;
  cval_t              node_c;
  logic [ID_BITS-1:0] hit_c;

  always_comb begin
    own_c  = cval_t'(own_id);
    node_c = cval_t'(in_node);
    hit_c  = '0;
    for (int i = 1; i < ID_BITS; i++) begin
      hit_c[i] = in_range(cval_t'(fingers[i]), own_c + cval_t'(1),
                          cval_t'(in_key) - cval_t'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_op        <= in_op;
      cap_node      <= in_node;
      cap_fidx      <= in_fidx;
      cap_hit       <= hit_c;
      cap_owns      <= in_range(cval_t'(in_key), own_c + cval_t'(1), cval_t'(succ));
      cap_succ_own  <= (succ == own_id);
      cap_notify_ok <= (pred == own_id) ||
                       in_range(node_c, cval_t'(pred) + cval_t'(1), own_c - cval_t'(1));
      cap_stab_ok   <= (in_node != own_id) &&
                       in_range(node_c, own_c + cval_t'(1), cval_t'(succ) - cval_t'(1));
    end
  end

  logic [ID_W-1:0]   hop;
  logic [PW-1:0]     ptr_next;
  logic [PW-1:0]     tgt_shift;
  logic [AW-1:0]     tgt_sum;
  logic [AW-1:0]     tgt;
  logic [ID_W-1:0]   succ_next;
  logic [ID_W-1:0]   pred_next;
  status_t           status_next;
  logic [ID_W-1:0]   node_next;
  logic [FIDX_W-1:0] fidx_next;

  always_comb begin
    hop = succ;
    for (int i = 1; i < ID_BITS; i++) begin
      if (cap_hit[i]) begin
        hop = fingers[i];
      end
    end
    ptr_next  = (ptr >= PW'(ID_BITS)) ? PW'(1) : ptr + PW'(1);
    tgt_shift = ptr_next - PW'(1);
    tgt_sum   = AW'(own_id) + (AW'(1) << tgt_shift);
    tgt       = tgt_sum & ID_MASK;

    succ_next   = succ;
    pred_next   = pred;
    status_next = ST_UPDATED;
    node_next   = '0;
    fidx_next   = '0;
    unique case (cap_op)
      OP_LOOKUP: begin
        if (cap_owns) begin
          status_next = ST_OWNS;
          node_next   = succ;
        end else begin
          status_next = ST_FORWARD;
          node_next   = cap_succ_own ? own_id : hop;
        end
      end
      OP_NEXT_TGT: begin
        status_next = ST_TARGET;
        node_next   = tgt[ID_W-1:0];
        fidx_next   = FIDX_W'(tgt_shift);
      end
      OP_NOTIFY: begin
        if (cap_notify_ok) begin
          pred_next = cap_node;
        end
      end
      OP_STABIL: begin
        if (cap_stab_ok) begin
          succ_next = cap_node;
        end
      end
      OP_SET_SUCC: begin
        succ_next = cap_node;
      end
      OP_RESTART: begin
        succ_next = own_id;
        pred_next = own_id;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id <= '0;
      succ   <= '0;
      pred   <= '0;
      ptr    <= '0;
      for (int i = 0; i < ID_BITS; i++) begin
        fingers[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        own_id <= cfg_wr_data;
      end
      if (cmd.execute) begin
        succ <= succ_next;
        pred <= pred_next;
        if (cap_op == OP_NEXT_TGT) begin
          ptr <= ptr_next;
        end else if (cap_op == OP_RESTART) begin
          ptr <= '0;
        end
        for (int i = 0; i < ID_BITS; i++) begin
          if (cap_op == OP_RESTART) begin
            fingers[i] <= own_id;
          end else if (cap_op == OP_WR_FING && int'(cap_fidx) == i) begin
            fingers[i] <= cap_node;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_status <= status_next;
      out_node   <= node_next;
      out_fidx   <= fidx_next;
      out_succ   <= succ_next;
      out_pred   <= pred_next;
    end
  end

  a_restart_self: assert property (@(posedge clk) disable iff (rst)
    cmd.execute && cap_op == OP_RESTART |=> succ == own_id && pred == own_id && ptr == '0)
    else $error("restart did not return the node to its own id");

endmodule

`default_nettype wire

[rtl/cftr_ctrl.sv]
// Controller of the finger table router: accept, execute and output handshake sequencing.
`default_nettype none

module cftr_ctrl import cftr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  output cftr_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  always_comb begin
    cmd.capture = in_valid && in_ready;
    cmd.execute = (state == S_EXEC) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
          if (cmd.capture) begin
            state    <= S_EXEC;
            in_ready <= 1'b0;
          end
        end
        S_EXEC: begin
          if (cmd.execute) begin
            state     <= S_IDLE;
            in_ready  <= 1'b1;
            out_valid <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready == (state == S_IDLE))
    else $error("input ready disagrees with controller state");

  a_capture_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == S_EXEC)
    else $error("accepted item was not taken into execution");

  a_exec_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> out_valid && state == S_IDLE)
    else $error("executed item did not produce a result");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC && out_valid && !out_ready |=> state == S_EXEC)
    else $error("execution overwrote a result not yet taken");

endmodule

`default_nettype wire

[rtl/chord_finger_table_router.sv]
// A result is offered once its item has passed the capture registers and the output register; an
// output stall delays it further.
// Each item executes before the next is accepted; the finger range compares run at the accept edge and
// the priority pick of the next hop plus the state update run in the execute cycle.
// The output register lets the next item be accepted while a result waits to be taken.
// Reset (rst, synchronous): own id, fingers, successor, predecessor and refresh pointer clear to zero.
// No item is in flight after reset and the block is ready at once.
`default_nettype none

module chord_finger_table_router import cftr_pkg::*; #(
  parameter int ID_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // key, node_id, finger_index
  input  wire logic [2:0]  s_axis_tuser,   // operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // node_id_res, finger_index_res, successor, predecessor
  output logic [1:0]       m_axis_tuser    // status
);

  cftr_cmd_t         cmd;
  logic [1:0]        out_status;
  logic [ID_W-1:0]   out_node;
  logic [FIDX_W-1:0] out_fidx;
  logic [ID_W-1:0]   out_succ;
  logic [ID_W-1:0]   out_pred;

  cftr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  cftr_dp #(
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_op       (s_axis_tuser),
    .in_key      (s_axis_tdata[15:0]),
    .in_node     (s_axis_tdata[31:16]),
    .in_fidx     (s_axis_tdata[35:32]),
    .out_status  (out_status),
    .out_node    (out_node),
    .out_fidx    (out_fidx),
    .out_succ    (out_succ),
    .out_pred    (out_pred)
  );

  assign m_axis_tdata = {4'd0, out_pred, out_succ, out_fidx, out_node};
  assign m_axis_tuser = out_status;

endmodule

`default_nettype wire
